[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the dual quadrature decoder.
// The bodies sample on clk and are disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define DQD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dqd_pkg.sv]
// Shared types, constants and the x4 transition table for the dual
// quadrature decoder. No dependencies.
`timescale 1ns / 1ps

package dqd_pkg;

  // Default widths
  localparam int DQD_COUNT_BITS      = 32;
  localparam int DQD_SCALE_FRAC_BITS = 16;

  // Datapath widths of the rate multiply
  localparam int RATE_W  = 32;
  localparam int SCALE_W = 32;
  localparam int MAG_W   = 64;
  localparam int SUM_W   = MAG_W + SCALE_W;

  // Pipeline depth: lane stages, then the output stage
  localparam int LANE_STG = 6;
  localparam int NUM_STG  = LANE_STG + 1;

  // Configuration space
  localparam int ADDR_W = 4;
  localparam int WIN_W  = 24;
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_CPS    = 2'd1;
  localparam logic [1:0] REG_RPM    = 2'd2;

  localparam logic [WIN_W-1:0]   WINDOW_RST = 24'd100000;
  localparam logic [SCALE_W-1:0] CPS_RST    = 32'd655360;
  localparam logic [SCALE_W-1:0] RPM_RST    = 32'd38400;

  // Saturation limits
  localparam logic [RATE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [RATE_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_FWD,
    STEP_REV
  } step_t;

  // Indexed by {previous A,B ; new A,B}
  localparam step_t STEP_TABLE [16] = '{
    STEP_NONE, STEP_REV,  STEP_FWD,  STEP_NONE,
    STEP_FWD,  STEP_NONE, STEP_NONE, STEP_REV,
    STEP_REV,  STEP_NONE, STEP_NONE, STEP_FWD,
    STEP_NONE, STEP_FWD,  STEP_REV,  STEP_NONE
  };

  // Control from the sequencer to each lane
  typedef struct packed {
    logic [LANE_STG:1] adv;
    logic              accept;
    logic              primed;
    logic              close;
  } dqd_ctl_t;

  // Control from the sequencer to the merge stage
  typedef struct packed {
    logic load;
    logic update;
    logic done;
  } dqd_mctl_t;

endpackage

[rtl/core/dqd_if.sv]
// Valid/ready channel interfaces for pin samples and decoded results.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

interface dqd_sample_if;
  logic valid;
  logic ready;
  logic enc1_a;
  logic enc1_b;
  logic enc2_a;
  logic enc2_b;

  modport source (output valid, enc1_a, enc1_b, enc2_a, enc2_b, input ready);
  modport sink   (input valid, enc1_a, enc1_b, enc2_a, enc2_b, output ready);
endinterface

interface dqd_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_1;
  logic signed [31:0] position_2;
  logic signed [31:0] rate_cps_1;
  logic signed [31:0] rate_cps_2;
  logic signed [31:0] rate_rpm_1;
  logic signed [31:0] rate_rpm_2;
  logic               window_done;

  modport source (output valid, position_1, position_2, rate_cps_1, rate_cps_2,
                  rate_rpm_1, rate_rpm_2, window_done, input ready);
  modport sink   (input valid, position_1, position_2, rate_cps_1, rate_cps_2,
                  rate_rpm_1, rate_rpm_2, window_done, output ready);
endinterface

[rtl/core/dqd_rate.sv]
// Pipelined signed delta times unsigned Q scale, saturated to 32 bits.
// Four stages: magnitude, 32x32 partial products, sum, shift and clamp.
`timescale 1ns / 1ps

module dqd_rate #(
  parameter int COUNT_BITS      = dqd_pkg::DQD_COUNT_BITS,
  parameter int SCALE_FRAC_BITS = dqd_pkg::DQD_SCALE_FRAC_BITS
) (
  input  logic                        clk,
  input  logic [3:0]                  adv,
  input  logic [COUNT_BITS-1:0]       delta,
  input  logic [dqd_pkg::SCALE_W-1:0] scale,
  output logic [dqd_pkg::RATE_W-1:0]  rate
);
  import dqd_pkg::*;

  logic [COUNT_BITS-1:0]   delta_neg;
  logic                    neg_a, neg_b, neg_c;
  logic [MAG_W-1:0]        mag_a;
  logic [2*SCALE_W-1:0]    p_lo, p_hi;
  logic [SUM_W-1:0]        sum_c;
  logic [SUM_W-1:0]        shifted;
  logic                    big;
  logic [RATE_W-1:0]       rate_next;

  assign delta_neg = ~delta + COUNT_BITS'(1);

  // Stage a: take the magnitude
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      neg_a <= delta[COUNT_BITS-1];
      mag_a <= MAG_W'(delta[COUNT_BITS-1] ? delta_neg : delta);
    end
  end

  // Stage b: low and high partial products
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      neg_b <= neg_a;
      p_lo  <= mag_a[SCALE_W-1:0] * scale;
      p_hi  <= mag_a[MAG_W-1:SCALE_W] * scale;
    end
  end

  // Stage c: combine the partial products
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      neg_c <= neg_b;
      sum_c <= {{SCALE_W{1'b0}}, p_lo} + {p_hi, {SCALE_W{1'b0}}};
    end
  end

  // Stage d: drop the fraction, apply the sign, clamp
  always_comb begin
    shifted = sum_c >> SCALE_FRAC_BITS;
    big     = |shifted[SUM_W-1:RATE_W-1];
    if (neg_c) begin
      rate_next = big ? SAT_NEG : (~shifted[RATE_W-1:0] + RATE_W'(1));
    end else begin
      rate_next = big ? SAT_POS : shifted[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      rate <= rate_next;
    end
  end

endmodule

[rtl/core/dqd_lane.sv]
// One encoder lane: x4 decode, position count, window delta and the two
// rate multipliers. Depends on dqd_pkg and dqd_rate.
`timescale 1ns / 1ps

module dqd_lane #(
  parameter int COUNT_BITS      = dqd_pkg::DQD_COUNT_BITS,
  parameter int SCALE_FRAC_BITS = dqd_pkg::DQD_SCALE_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dqd_pkg::dqd_ctl_t           ctl,
  input  logic [1:0]                  pins,
  input  logic [dqd_pkg::SCALE_W-1:0] cps_scale,
  input  logic [dqd_pkg::SCALE_W-1:0] rpm_scale,
  output logic [COUNT_BITS-1:0]       pos,
  output logic [dqd_pkg::RATE_W-1:0]  cps,
  output logic [dqd_pkg::RATE_W-1:0]  rpm
);
  import dqd_pkg::*;

  logic [1:0]            prev_pins;
  logic [COUNT_BITS-1:0] pos_count, pos_count_next, window_start;
  step_t                 step;
  logic [COUNT_BITS-1:0] pos_s1, start_s1, delta_s2;
  logic [COUNT_BITS-1:0] pos_d [2:LANE_STG];

  // Decode the transition and move the count
  always_comb begin
    step = STEP_TABLE[{prev_pins, pins}];
    pos_count_next = pos_count;
    if (ctl.primed) begin
      case (step)
        STEP_FWD: pos_count_next = pos_count + COUNT_BITS'(1);
        STEP_REV: pos_count_next = pos_count - COUNT_BITS'(1);
        default:  pos_count_next = pos_count;
      endcase
    end
  end

  // Lane state advances on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins    <= '0;
      pos_count    <= '0;
      window_start <= '0;
    end else if (ctl.accept) begin
      prev_pins <= pins;
      pos_count <= pos_count_next;
      if (ctl.close) begin
        window_start <= pos_count_next;
      end
    end
  end

  // Stage 1: capture count and window start
  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      pos_s1   <= pos_count_next;
      start_s1 <= window_start;
    end
  end

  // Stage 2: window delta
  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      pos_d[2] <= pos_s1;
      delta_s2 <= pos_s1 - start_s1;
    end
  end

  // Carry the position alongside the multipliers
  always_ff @(posedge clk) begin
    for (int k = 3; k <= LANE_STG; k++) begin
      if (ctl.adv[k]) begin
        pos_d[k] <= pos_d[k-1];
      end
    end
  end

  assign pos = pos_d[LANE_STG];

  dqd_rate #(
    .COUNT_BITS      (COUNT_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_cps (
    .clk   (clk),
    .adv   (ctl.adv[LANE_STG:3]),
    .delta (delta_s2),
    .scale (cps_scale),
    .rate  (cps)
  );

  dqd_rate #(
    .COUNT_BITS      (COUNT_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_rpm (
    .clk   (clk),
    .adv   (ctl.adv[LANE_STG:3]),
    .delta (delta_s2),
    .scale (rpm_scale),
    .rate  (rpm)
  );

endmodule

[rtl/core/dqd_merge.sv]
// Output stage: combines both lanes into one result beat and keeps the
// speed registers of the last closed window. Depends on dqd_pkg.
`timescale 1ns / 1ps

module dqd_merge #(
  parameter int COUNT_BITS = dqd_pkg::DQD_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dqd_pkg::dqd_mctl_t                ctl,
  input  logic [COUNT_BITS-1:0]             pos_1,
  input  logic [COUNT_BITS-1:0]             pos_2,
  input  logic [dqd_pkg::RATE_W-1:0]        cps_1,
  input  logic [dqd_pkg::RATE_W-1:0]        cps_2,
  input  logic [dqd_pkg::RATE_W-1:0]        rpm_1,
  input  logic [dqd_pkg::RATE_W-1:0]        rpm_2,
  output logic signed [dqd_pkg::RATE_W-1:0] position_1,
  output logic signed [dqd_pkg::RATE_W-1:0] position_2,
  output logic signed [dqd_pkg::RATE_W-1:0] rate_cps_1,
  output logic signed [dqd_pkg::RATE_W-1:0] rate_cps_2,
  output logic signed [dqd_pkg::RATE_W-1:0] rate_rpm_1,
  output logic signed [dqd_pkg::RATE_W-1:0] rate_rpm_2,
  output logic                              window_done
);
  import dqd_pkg::*;

  // Speeds hold until the next window closes
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_cps_1 <= '0;
      rate_cps_2 <= '0;
      rate_rpm_1 <= '0;
      rate_rpm_2 <= '0;
    end else if (ctl.update) begin
      rate_cps_1 <= signed'(cps_1);
      rate_cps_2 <= signed'(cps_2);
      rate_rpm_1 <= signed'(rpm_1);
      rate_rpm_2 <= signed'(rpm_2);
    end
  end

  // Positions sign extended or cut to the port width
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      position_1  <= RATE_W'(signed'(pos_1));
      position_2  <= RATE_W'(signed'(pos_2));
      window_done <= ctl.done;
    end
  end

endmodule

[rtl/core/dual_quadrature_decoder_speed_top.sv]
// A sample beat, once accepted, passes the lane stages and the output stage.
// Throughput: one sample per cycle; the seven-stage pipeline with per-stage
// valid bits closes bubbles, so a stalled result only blocks once all stages hold.
// Reset (rst, synchronous): counts, pin history, window counter and speeds
// clear to zero, registers return to 100000 / 655360 / 38400; no clearing pass.
`timescale 1ns / 1ps

module dual_quadrature_decoder_speed_top #(
  parameter int COUNT_BITS      = dqd_pkg::DQD_COUNT_BITS,
  parameter int SCALE_FRAC_BITS = dqd_pkg::DQD_SCALE_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  dqd_sample_if.sink                  sample_ch,
  dqd_result_if.source                result_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dqd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import dqd_pkg::*;

  `include "assert_macros.svh"

  logic [WIN_W-1:0]    window_samples;
  logic [SCALE_W-1:0]  cps_scale, rpm_scale;
  logic [ADDR_W-3:0]   reg_idx;
  logic                cfg_wr;

  logic [WIN_W-1:0]    sample_counter;
  logic                primed;
  logic [WIN_W-1:0]    ws_eff;
  logic [WIN_W:0]      cnt_inc;
  logic                close;
  logic                accept;

  logic [NUM_STG+1:1]  en;
  logic [NUM_STG:1]    stg_v;
  logic [NUM_STG:1]    v_in;
  logic [LANE_STG:1]   done_d;

  dqd_ctl_t            ctl;
  dqd_mctl_t           mctl;

  logic [COUNT_BITS-1:0] pos_1, pos_2;
  logic [RATE_W-1:0]     cps_1, cps_2, rpm_1, rpm_2;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples <= WINDOW_RST;
      cps_scale      <= CPS_RST;
      rpm_scale      <= RPM_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WINDOW: window_samples <= pwdata[WIN_W-1:0];
        REG_CPS:    cps_scale      <= pwdata;
        REG_RPM:    rpm_scale      <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW: prdata = 32'(window_samples);
      REG_CPS:    prdata = cps_scale;
      REG_RPM:    prdata = rpm_scale;
      default:    prdata = '0;
    endcase
  end

  // Stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NUM_STG+1] = result_ch.ready;
    for (int k = NUM_STG; k >= 1; k--) begin
      en[k] = !stg_v[k] || en[k+1];
    end
  end

  assign sample_ch.ready = en[1];
  assign accept          = sample_ch.valid && en[1];
  assign v_in            = {stg_v[NUM_STG-1:1], sample_ch.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v <= '0;
    end else begin
      for (int k = 1; k <= NUM_STG; k++) begin
        if (en[k]) begin
          stg_v[k] <= v_in[k];
        end
      end
    end
  end

  // Window sequencing
  assign ws_eff  = (window_samples == '0) ? WIN_W'(1) : window_samples;
  assign cnt_inc = {1'b0, sample_counter} + (WIN_W+1)'(1);
  assign close   = cnt_inc >= {1'b0, ws_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      primed         <= 1'b0;
    end else if (accept) begin
      primed         <= 1'b1;
      sample_counter <= close ? '0 : cnt_inc[WIN_W-1:0];
    end
  end

  // Carry the window flag down the pipe
  always_ff @(posedge clk) begin
    if (en[1]) begin
      done_d[1] <= close;
    end
    for (int k = 2; k <= LANE_STG; k++) begin
      if (en[k]) begin
        done_d[k] <= done_d[k-1];
      end
    end
  end

  always_comb begin
    ctl.adv     = en[LANE_STG:1];
    ctl.accept  = accept;
    ctl.primed  = primed;
    ctl.close   = close;
    mctl.load   = en[NUM_STG];
    mctl.update = en[NUM_STG] && stg_v[LANE_STG] && done_d[LANE_STG];
    mctl.done   = done_d[LANE_STG];
  end

  dqd_lane #(
    .COUNT_BITS      (COUNT_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_lane_1 (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .pins      ({sample_ch.enc1_a, sample_ch.enc1_b}),
    .cps_scale (cps_scale),
    .rpm_scale (rpm_scale),
    .pos       (pos_1),
    .cps       (cps_1),
    .rpm       (rpm_1)
  );

  dqd_lane #(
    .COUNT_BITS      (COUNT_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_lane_2 (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .pins      ({sample_ch.enc2_a, sample_ch.enc2_b}),
    .cps_scale (cps_scale),
    .rpm_scale (rpm_scale),
    .pos       (pos_2),
    .cps       (cps_2),
    .rpm       (rpm_2)
  );

  dqd_merge #(
    .COUNT_BITS (COUNT_BITS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (mctl),
    .pos_1       (pos_1),
    .pos_2       (pos_2),
    .cps_1       (cps_1),
    .cps_2       (cps_2),
    .rpm_1       (rpm_1),
    .rpm_2       (rpm_2),
    .position_1  (result_ch.position_1),
    .position_2  (result_ch.position_2),
    .rate_cps_1  (result_ch.rate_cps_1),
    .rate_cps_2  (result_ch.rate_cps_2),
    .rate_rpm_1  (result_ch.rate_rpm_1),
    .rate_rpm_2  (result_ch.rate_rpm_2),
    .window_done (result_ch.window_done)
  );

  assign result_ch.valid = stg_v[NUM_STG];

  // Checks
  `DQD_ASSERT_NOW(a_full_on_stall, !en[1], &stg_v, "input stalled with an empty stage")
  `DQD_ASSERT_NEXT(a_close_clears, accept && close, sample_counter == '0, "window counter not cleared")
  `DQD_ASSERT_NEXT(a_primed_after, accept, primed, "not primed after a sample beat")

endmodule

[tb/tb.sv]
// Self-checking bench for dual_quadrature_decoder_speed_top: x4 decode of two
// encoders and windowed speed, checked beat by beat against a built-in predictor.
// Depends on dqd_pkg, the dqd_sample_if / dqd_result_if interfaces and the top level.
`timescale 1ns / 1ps

module tb;
  import dqd_pkg::*;

  typedef struct packed {
    logic enc1_a;
    logic enc1_b;
    logic enc2_a;
    logic enc2_b;
  } pin_sample_t;

  typedef struct packed {
    logic [31:0] position_1;
    logic [31:0] position_2;
    logic [31:0] rate_cps_1;
    logic [31:0] rate_cps_2;
    logic [31:0] rate_rpm_1;
    logic [31:0] rate_rpm_2;
    logic        window_done;
  } decoded_t;

  // x4 decode, indexed by {previous A,B ; new A,B}
  localparam step_t X4_DECODE [16] = '{
    STEP_NONE, STEP_REV,  STEP_FWD,  STEP_NONE,
    STEP_FWD,  STEP_NONE, STEP_NONE, STEP_REV,
    STEP_REV,  STEP_NONE, STEP_NONE, STEP_FWD,
    STEP_NONE, STEP_FWD,  STEP_REV,  STEP_NONE
  };

  // Forward order of the pin states
  localparam logic [1:0] GRAY_CYCLE [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

  // Pin tours that pass every one of the 16 transitions, after a load-only first sample
  localparam logic [1:0] TOUR_1 [18] = '{2'd3, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3,
                                         2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
  localparam logic [1:0] TOUR_2 [18] = '{2'd1, 2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd3, 2'd0, 2'd2,
                                         2'd0, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Sample source side
  logic        s_valid = 1'b0;
  pin_sample_t s_pins  = '0;
  // Result sink side
  logic        r_ready = 1'b0;
  // Register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  dqd_sample_if sample_ch ();
  dqd_result_if result_ch ();

  assign sample_ch.valid  = s_valid;
  assign sample_ch.enc1_a = s_pins.enc1_a;
  assign sample_ch.enc1_b = s_pins.enc1_b;
  assign sample_ch.enc2_a = s_pins.enc2_a;
  assign sample_ch.enc2_b = s_pins.enc2_b;
  assign result_ch.ready  = r_ready;

  dual_quadrature_decoder_speed_top dut (
    .clk      (clk),
    .rst      (rst),
    .sample_ch(sample_ch),
    .result_ch(result_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor copy of the registers
  logic [23:0] cfg_window = 24'd100000;
  logic [31:0] cfg_cps    = 32'd655360;
  logic [31:0] cfg_rpm    = 32'd38400;

  // Predictor copy of the decoder state
  logic [1:0]  prev_ab_1 = '0;
  logic [1:0]  prev_ab_2 = '0;
  bit          seen_first = 1'b0;
  logic [31:0] count_1 = '0;
  logic [31:0] count_2 = '0;
  logic [31:0] mark_1 = '0;
  logic [31:0] mark_2 = '0;
  int unsigned win_fill = 0;
  logic [31:0] speed_cps_1 = '0;
  logic [31:0] speed_cps_2 = '0;
  logic [31:0] speed_rpm_1 = '0;
  logic [31:0] speed_rpm_2 = '0;

  pin_sample_t pending_pins[$];
  decoded_t    expected_results[$];

  // Walk generator state per encoder
  int walk_pos [2] = '{0, 0};
  int walk_dir [2] = '{1, -1};

  // Source burst pattern and sink stall pattern
  int burst_left  = 1;
  int gap_left    = 0;
  bit steady_feed = 1'b0;
  int run_left    = 0;
  int stall_left  = 0;
  int hold_off    = 0;
  int beats       = 0;
  int mismatches  = 0;

  function automatic logic [31:0] step_count(logic [31:0] cnt, logic [1:0] from_ab,
                                             logic [1:0] to_ab);
    case (X4_DECODE[{from_ab, to_ab}])
      STEP_FWD: return cnt + 32'd1;
      STEP_REV: return cnt - 32'd1;
      default:  return cnt;
    endcase
  endfunction

  // Signed delta times unsigned Q scale, truncated toward zero, saturated to s32
  function automatic logic [31:0] scale_rate(logic [31:0] delta, logic [31:0] scale);
    logic [31:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    mag  = delta[31] ? (~delta + 32'd1) : delta;
    prod = {32'd0, mag} * {32'd0, scale};
    q    = prod >> DQD_SCALE_FRAC_BITS;
    if (delta[31]) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return ~q[31:0] + 32'd1;
    end
    if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // Advance the predictor by one accepted sample and return its result
  function automatic decoded_t decode_sample(pin_sample_t s);
    logic [1:0]  ab_1;
    logic [1:0]  ab_2;
    int unsigned span;
    int unsigned next_fill;
    decoded_t    r;
    ab_1      = {s.enc1_a, s.enc1_b};
    ab_2      = {s.enc2_a, s.enc2_b};
    span      = (cfg_window == 24'd0) ? 1 : int'(cfg_window);
    next_fill = win_fill + 1;
    // first sample after reset only loads the pin history
    if (seen_first) begin
      count_1 = step_count(count_1, prev_ab_1, ab_1);
      count_2 = step_count(count_2, prev_ab_2, ab_2);
    end
    seen_first = 1'b1;
    prev_ab_1  = ab_1;
    prev_ab_2  = ab_2;
    r.window_done = 1'b0;
    if (next_fill >= span) begin
      speed_cps_1 = scale_rate(count_1 - mark_1, cfg_cps);
      speed_cps_2 = scale_rate(count_2 - mark_2, cfg_cps);
      speed_rpm_1 = scale_rate(count_1 - mark_1, cfg_rpm);
      speed_rpm_2 = scale_rate(count_2 - mark_2, cfg_rpm);
      mark_1   = count_1;
      mark_2   = count_2;
      win_fill = 0;
      r.window_done = 1'b1;
    end else begin
      win_fill = next_fill;
    end
    r.position_1 = count_1;
    r.position_2 = count_2;
    r.rate_cps_1 = speed_cps_1;
    r.rate_cps_2 = speed_cps_2;
    r.rate_rpm_1 = speed_rpm_1;
    r.rate_rpm_2 = speed_rpm_2;
    return r;
  endfunction

  // Mostly legal quadrature motion with direction changes; some random pin noise
  function automatic logic [1:0] walk_channel(int ch, int noise_pct);
    if ($urandom_range(0, 99) < noise_pct) return 2'($urandom_range(0, 3));
    if ($urandom_range(0, 15) == 0) walk_dir[ch] = int'($urandom_range(0, 2)) - 1;
    walk_pos[ch] = (walk_pos[ch] + walk_dir[ch] + 4) % 4;
    return GRAY_CYCLE[walk_pos[ch]];
  endfunction

  task automatic push_walk(int count, int noise_pct);
    for (int i = 0; i < count; i++)
      pending_pins.push_back(pin_sample_t'({walk_channel(0, noise_pct),
                                            walk_channel(1, noise_pct)}));
  endtask

  // Drain: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pins.size() != 0 || s_valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_WINDOW: cfg_window = value[23:0];
      REG_CPS:    cfg_cps    = value;
      REG_RPM:    cfg_rpm    = value;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
    end
  endtask

  initial forever #10 clk = ~clk;

  // Sample driver: bursts from the pending queue, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && sample_ch.ready)
        expected_results.push_back(decode_sample(s_pins));
      if (s_valid && !sample_ch.ready) begin
        // hold the beat until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (pending_pins.size() > 0) begin
        s_pins  <= pending_pins.pop_front();
        s_valid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          if (steady_feed || $urandom_range(0, 3) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 6);
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Result monitor and sink stall pattern
  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      r_ready <= 1'b0;
    end else begin
      if (result_ch.valid && r_ready) begin
        beats++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("result beat with no sample outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("position_1", want.position_1, result_ch.position_1);
          check_field("position_2", want.position_2, result_ch.position_2);
          check_field("rate_cps_1", want.rate_cps_1, result_ch.rate_cps_1);
          check_field("rate_cps_2", want.rate_cps_2, result_ch.rate_cps_2);
          check_field("rate_rpm_1", want.rate_rpm_1, result_ch.rate_rpm_1);
          check_field("rate_rpm_2", want.rate_rpm_2, result_ch.rate_rpm_2);
          check_field("window_done", 32'(want.window_done), 32'(result_ch.window_done));
        end
        // long hold-off now and then so the pipeline fills and backs up
        if (beats % 700 == 350) hold_off = 90;
      end
      if (hold_off > 0) begin
        hold_off--;
        r_ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        r_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        r_ready <= 1'b0;
      end else begin
        run_left = $urandom_range(0, 40);
        if ($urandom_range(0, 2) == 0) stall_left = 0;
        else stall_left = $urandom_range(1, 4);
        r_ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Every transition on both encoders, reset register values, no window closes
    for (int i = 0; i < 18; i++)
      pending_pins.push_back(pin_sample_t'({TOUR_1[i], TOUR_2[i]}));
    wait_idle();

    // Upper bits dropped; the window now sits below the running count
    write_reg(REG_WINDOW, 32'hFF00_0004);
    push_walk(150, 10);
    wait_idle();

    // Zero window closes on every sample; scale extremes
    write_reg(REG_WINDOW, 32'd0);
    write_reg(REG_CPS, 32'hFFFF_FFFF);
    write_reg(REG_RPM, 32'd0);
    push_walk(120, 10);
    wait_idle();

    write_reg(REG_WINDOW, 32'd1);
    write_reg(REG_CPS, 32'd1);
    write_reg(REG_RPM, 32'h0001_0000);
    push_walk(100, 10);
    wait_idle();

    repeat (8) begin
      write_reg(REG_WINDOW, $urandom_range(2, 40));
      write_reg(REG_CPS, $urandom);
      write_reg(REG_RPM, $urandom_range(0, 32'h0010_0000));
      push_walk(100, 12);
      wait_idle();
    end

    // Longest window, then cut short so it closes at once
    write_reg(REG_WINDOW, 32'h00FF_FFFF);
    push_walk(80, 5);
    wait_idle();
    write_reg(REG_WINDOW, 32'd3);
    push_walk(40, 5);
    wait_idle();

    // Steady opposite motion fed back to back under wide scales
    write_reg(REG_WINDOW, 32'd120);
    write_reg(REG_CPS, 32'hFFFF_FFFF);
    write_reg(REG_RPM, 32'h8000_0000);
    steady_feed = 1'b1;
    for (int i = 0; i < 160; i++) begin
      walk_pos[0] = (walk_pos[0] + 1) % 4;
      walk_pos[1] = (walk_pos[1] + 3) % 4;
      pending_pins.push_back(pin_sample_t'({GRAY_CYCLE[walk_pos[0]],
                                            GRAY_CYCLE[walk_pos[1]]}));
    end
    wait_idle();
    steady_feed = 1'b0;

    // Noisier tail
    write_reg(REG_WINDOW, $urandom_range(5, 25));
    write_reg(REG_CPS, $urandom);
    write_reg(REG_RPM, $urandom);
    push_walk(150, 25);
    wait_idle();

    repeat (12) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/dqd_pkg.sv
rtl/core/dqd_if.sv
rtl/core/dqd_rate.sv
rtl/core/dqd_lane.sv
rtl/core/dqd_merge.sv
rtl/core/dual_quadrature_decoder_speed_top.sv
tb/tb.sv
